[rtl/i2cbe_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared codes, widths and the command/status bundles of the I2C bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_W     = $clog2(DATA_BITS);
  localparam int OP_W      = 3;

  localparam int IN_W  = 24;
  localparam int OUT_W = 16;

  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_TX_ACK = 3'd4;
  localparam logic [OP_W-1:0] OP_RX_ACK = 3'd5;

  typedef enum logic [1:0] {
    SDA_ONE,
    SDA_ZERO,
    SDA_WBIT,
    SDA_ACK
  } sda_src_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    logic     scl_we;
    logic     scl_val;
    logic     sda_we;
    sda_src_t sda_src;
    logic     shift_w;
    logic     sample_rd;
    logic     sample_ack;
    logic     last;
    logic     show_rd;
    logic     show_ack;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } stat_t;

endpackage

[rtl/i2cbe_datapath.sv]
// ----------------------------------------------------------------------------
// i2cbe_datapath
// Line drive registers, shift registers for write and slave data, read
// accumulator and the registered phase output.
// ----------------------------------------------------------------------------
module i2cbe_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  i2cbe_pkg::cmd_t            cmd,
  output i2cbe_pkg::stat_t           stat,
  input  logic [i2cbe_pkg::DATA_BITS-1:0] write_data,
  input  logic                       ack_to_send,
  input  logic [i2cbe_pkg::DATA_BITS-1:0] slave_bits,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_scl,
  output logic                       out_sda,
  output logic                       out_last,
  output logic [i2cbe_pkg::DATA_BITS-1:0] out_read_data,
  output logic                       out_ack
);
  import i2cbe_pkg::*;

  logic                 scl;
  logic                 sda;
  logic                 scl_next;
  logic                 sda_next;
  logic [DATA_BITS-1:0] wshift;
  logic [DATA_BITS-1:0] sshift;
  logic [DATA_BITS-1:0] acc;
  logic                 ack_val;
  logic                 ack_smp;

  assign stat.slot_free = !out_valid || out_ready;

  always_comb begin
    scl_next = cmd.scl_we ? cmd.scl_val : scl;
    sda_next = sda;
    if (cmd.sda_we) begin
      unique case (cmd.sda_src)
        SDA_ONE:  sda_next = 1'b1;
        SDA_ZERO: sda_next = 1'b0;
        SDA_WBIT: sda_next = wshift[DATA_BITS-1];
        SDA_ACK:  sda_next = ack_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl       <= 1'b1;
      sda       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        scl       <= scl_next;
        sda       <= sda_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wshift  <= write_data;
      sshift  <= slave_bits;
      ack_val <= ack_to_send;
      acc     <= '0;
      ack_smp <= 1'b0;
    end else if (cmd.emit) begin
      if (cmd.shift_w) begin
        wshift <= {wshift[DATA_BITS-2:0], 1'b0};
      end
      if (cmd.sample_rd) begin
        acc    <= {acc[DATA_BITS-2:0], sshift[DATA_BITS-1]};
        sshift <= {sshift[DATA_BITS-2:0], 1'b0};
      end
      if (cmd.sample_ack) begin
        ack_smp <= sshift[DATA_BITS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_scl       <= scl_next;
      out_sda       <= sda_next;
      out_last      <= cmd.last;
      out_read_data <= cmd.show_rd ? acc : '0;
      out_ack       <= cmd.show_ack ? ack_smp : 1'b0;
    end
  end

  a_one_line: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $onehot0({cmd.scl_we, cmd.sda_we}))
    else $error("phase changes both lines");

  a_rd_on_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.show_rd) |-> cmd.last)
    else $error("read data shown before last phase");

  a_ack_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_ack == 1'b0 || out_last))
    else $error("ack shown before last phase");

endmodule

[rtl/i2cbe_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cbe_ctrl
// Command sequencer: takes one command, then steps through its line phases,
// one per free output slot.
// ----------------------------------------------------------------------------
module i2cbe_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [i2cbe_pkg::OP_W-1:0] op_in,
  input  i2cbe_pkg::stat_t           stat,
  output i2cbe_pkg::cmd_t            cmd
);
  import i2cbe_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [1:0] SUB_LAST3 = 2'd2;
  localparam logic [1:0] SUB_LAST4 = 2'd3;
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DATA_BITS - 1);

  logic             state;
  logic             state_next;
  logic [OP_W-1:0]  op;
  logic [1:0]       sub;
  logic [1:0]       sub_next;
  logic [BIT_W-1:0] bit_idx;
  logic [BIT_W-1:0] bit_idx_next;
  logic             op_ok;

  assign cmd_ready = (state == ST_IDLE);
  assign op_ok     = (op_in <= OP_RX_ACK);

  always_comb begin
    cmd          = '0;
    cmd.sda_src  = SDA_ONE;
    cmd.load     = cmd_valid && cmd_ready;
    state_next   = state;
    sub_next     = sub;
    bit_idx_next = bit_idx;
    if (state == ST_IDLE) begin
      if (cmd_valid && op_ok) begin
        state_next   = ST_RUN;
        sub_next     = '0;
        bit_idx_next = '0;
      end
    end else if (stat.slot_free) begin
      cmd.emit = 1'b1;
      sub_next = sub + 2'd1;
      unique case (op)
        OP_START: begin
          unique case (sub)
            2'd0: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b1; end
            2'd1: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ONE; end
            2'd2: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ZERO; end
            default: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b0; end
          endcase
          cmd.last = (sub == SUB_LAST4);
        end
        OP_STOP: begin
          unique case (sub)
            2'd0: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ZERO; end
            2'd1: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b1; end
            default: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ONE; end
          endcase
          cmd.last = (sub == SUB_LAST3);
        end
        OP_WRITE: begin
          unique case (sub)
            2'd0: begin
              cmd.sda_we  = 1'b1;
              cmd.sda_src = SDA_WBIT;
              cmd.shift_w = 1'b1;
            end
            2'd1: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b1; end
            default: begin
              cmd.scl_we   = 1'b1;
              cmd.scl_val  = 1'b0;
              sub_next     = 2'd0;
              bit_idx_next = bit_idx + 1'b1;
            end
          endcase
          cmd.last = (sub == SUB_LAST3) && (bit_idx == BIT_LAST);
        end
        OP_READ: begin
          unique case (sub)
            2'd0: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ONE; end
            2'd1: begin
              cmd.scl_we    = 1'b1;
              cmd.scl_val   = 1'b1;
              cmd.sample_rd = 1'b1;
            end
            default: begin
              cmd.scl_we   = 1'b1;
              cmd.scl_val  = 1'b0;
              sub_next     = 2'd1;
              bit_idx_next = bit_idx + 1'b1;
            end
          endcase
          cmd.last    = (sub == SUB_LAST3) && (bit_idx == BIT_LAST);
          cmd.show_rd = cmd.last;
        end
        OP_TX_ACK: begin
          unique case (sub)
            2'd0: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ACK; end
            2'd1: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b1; end
            default: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b0; end
          endcase
          cmd.last = (sub == SUB_LAST3);
        end
        OP_RX_ACK: begin
          unique case (sub)
            2'd0: begin cmd.sda_we = 1'b1; cmd.sda_src = SDA_ONE; end
            2'd1: begin
              cmd.scl_we     = 1'b1;
              cmd.scl_val    = 1'b1;
              cmd.sample_ack = 1'b1;
            end
            default: begin cmd.scl_we = 1'b1; cmd.scl_val = 1'b0; end
          endcase
          cmd.last     = (sub == SUB_LAST3);
          cmd.show_ack = cmd.last;
        end
        default: begin
          cmd.emit = 1'b0;
          cmd.last = 1'b0;
        end
      endcase
      if (cmd.last || !cmd.emit) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sub     <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      sub     <= sub_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.slot_free)
    else $error("phase issued into a full output slot");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("sequencer kept running after last phase");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !cmd.emit)
    else $error("phase issued while idle");

endmodule

[rtl/i2c_master_bit_engine_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Command-level I2C master: each command becomes a run of line phases, one
// transaction on the result stream per phase.
//
//   Channel  Dir  tdata (low bit up)                                  Extra
//   s_*      in   operation[2:0] write_data[10:3] ack_to_send[11]     -
//                 slave_bits[19:12], zero pad to 24
//   m_*      out  scl_level[0] sda_level[1] read_data[9:2]            tlast=last_phase
//                 ack_seen[10], zero pad to 16
//
// A command is taken only while the sequencer is idle, then one phase leaves
// per cycle unless m_tready stalls the output slot.
// Codes 6 and 7 are taken and dropped without results.
// A stalled m_tready holds the phase output register and freezes the sequence.
// Synchronous reset releases both lines (drive levels 1) and empties the output.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [i2cbe_pkg::IN_W-1:0]  s_tdata,  // operation, write_data, ack_to_send, slave_bits
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [i2cbe_pkg::OUT_W-1:0] m_tdata,  // scl_level, sda_level, read_data, ack_seen
  output logic                        m_tlast
);
  import i2cbe_pkg::*;

  cmd_t                 cmd;
  stat_t                stat;
  logic                 out_scl;
  logic                 out_sda;
  logic [DATA_BITS-1:0] out_read_data;
  logic                 out_ack;

  i2cbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .op_in     (s_tdata[OP_W-1:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2cbe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .write_data    (s_tdata[OP_W +: DATA_BITS]),
    .ack_to_send   (s_tdata[OP_W + DATA_BITS]),
    .slave_bits    (s_tdata[OP_W + DATA_BITS + 1 +: DATA_BITS]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_scl       (out_scl),
    .out_sda       (out_sda),
    .out_last      (m_tlast),
    .out_read_data (out_read_data),
    .out_ack       (out_ack)
  );

  assign m_tdata = {{(OUT_W - DATA_BITS - 3){1'b0}}, out_ack, out_read_data, out_sda, out_scl};

endmodule
